// ----- rtl/nsts_pkg.sv -----
// Shared types, constants and saturation helpers for the stencil term sum.
`timescale 1ns / 1ps
`default_nettype none

package nsts_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TERM_SLOTS = 4;
  localparam int unsigned COEFF_REGS = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned KINDS_W    = COEFF_REGS * KIND_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WIDE_W     = 66;
  localparam int unsigned IN_FIELDS  = 7;
  localparam int unsigned STAGES     = 7;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_DX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_DY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_DZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_KINDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_2    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_3    = 3'd7;

  localparam logic [DATA_W-1:0]  INV_DX_RST = 32'd65536;
  localparam logic [DATA_W-1:0]  INV_DY_RST = 32'd65536;
  localparam logic [DATA_W-1:0]  INV_DZ_RST = 32'd0;
  localparam logic [KINDS_W-1:0] KINDS_RST  = 12'hFFF;

  localparam logic signed [WIDE_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [KIND_W-1:0] {
    KIND_UUX  = 3'd0,
    KIND_UUY  = 3'd1,
    KIND_UUZ  = 3'd2,
    KIND_UXUX = 3'd3,
    KIND_UYUY = 3'd4,
    KIND_UZUZ = 3'd5,
    KIND_GRAD = 3'd6,
    KIND_NONE = 3'd7
  } kind_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } sat_t;

  // stage enables of one derivative lane
  typedef struct packed {
    logic diff;
    logic prod;
    logic sat;
  } deriv_en_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > S32_MAX) begin
      r.val  = S32_MAX[DATA_W-1:0];
      r.clip = 1'b1;
    end else if (v < S32_MIN) begin
      r.val  = S32_MIN[DATA_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[DATA_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // floor-rounded fixed point rescale of a full product, then clip
  function automatic sat_t shift_sat(input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] sh;
    sh = p >>> FRAC_BITS;
    return sat32(sh);
  endfunction

  function automatic logic signed [2*DATA_W-1:0] mul32(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [2*DATA_W-1:0] ae;
    logic signed [2*DATA_W-1:0] be;
    ae = {{DATA_W{a[DATA_W-1]}}, a};
    be = {{DATA_W{b[DATA_W-1]}}, b};
    return ae * be;
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext64(input logic signed [2*DATA_W-1:0] v);
    return {{(WIDE_W-2*DATA_W){v[2*DATA_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nsts_deriv.sv -----
// One central-difference lane: difference, scale by inverse spacing, rescale and clip.
`timescale 1ns / 1ps
`default_nettype none

module nsts_deriv
  import nsts_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire deriv_en_t                en_i,
  input  wire logic signed [DATA_W-1:0] plus_i,
  input  wire logic signed [DATA_W-1:0] minus_i,
  input  wire logic        [DATA_W-1:0] inv_i,
  output logic signed      [DATA_W-1:0] deriv_o,
  output logic                          clip_o
);

  logic signed [DATA_W:0]   diff_d, diff_q;
  logic signed [WIDE_W-1:0] prod_d, prod_q;
  sat_t                     res_d;
  logic signed [DATA_W-1:0] deriv_q;
  logic                     clip_q;

  assign diff_d = $signed({plus_i[DATA_W-1], plus_i}) - $signed({minus_i[DATA_W-1], minus_i});
  // 33 x 33 signed product, spacing zero-extended
  assign prod_d = $signed({{(WIDE_W-DATA_W-1){diff_q[DATA_W]}}, diff_q})
                * $signed({{(WIDE_W-DATA_W){1'b0}}, inv_i});
  assign res_d  = shift_sat(prod_q);

  always_ff @(posedge clk_i) begin
    if (en_i.diff) begin
      diff_q <= diff_d;
    end
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
    if (en_i.sat) begin
      deriv_q <= res_d.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (en_i.sat) begin
      clip_q <= res_d.clip;
    end
  end

  assign deriv_o = deriv_q;
  assign clip_o  = clip_q;

endmodule

`default_nettype wire

// ----- rtl/nonlinear_stencil_term_sum.sv -----
// Top level: seven-point stencil derivatives and configured nonlinear term sum.
//
// Usage: one word on the slave stream carries a grid point's center value and its
// six axis neighbors (Q16.16 each). The block forms ux, uy, uz by central
// difference times the software-supplied inverse of twice the spacing, then adds
// up to four configured terms, each a kind times a coefficient. One master word
// comes out per input word: the saturated Q16.16 sum in tdata and a clip flag in
// tuser. Writing zero to the inverse z spacing gives the 2D rule set.
// Throughput: one word per cycle while the master side is ready; set by the seven-stage
// register pipeline, whose longest steps are the 33x33 derivative multiply and the 32x32 term multiplies.
// Stalls: each stage holds while the stage after it is full and blocked; empty
// stages fill, so the slave side keeps taking words until all seven are full.
// Reset: the pipeline empties and the registers return to 1/(2dx) = 1/(2dy) = 1.0,
// 1/(2dz) = 0 (2D), all term kinds none, coefficients zero. Registers must be written
// only while no word is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module nonlinear_stencil_term_sum
  import nsts_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // slave stream: tdata = u_center, u_x_minus, u_x_plus, u_y_minus, u_y_plus,
  //               u_z_minus, u_z_plus (32 bits each, lowest first)
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [IN_FIELDS*DATA_W-1:0] s_axis_tdata,
  // master stream: tdata = term_sum; tuser = saturated
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [DATA_W-1:0]             m_axis_tdata,
  output logic                          m_axis_tuser,
  // register write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [DATA_W-1:0]        cfg_wdata_i
);

  // ---------------------------------------------------------------- registers
  logic        [DATA_W-1:0]  inv_dx_q, inv_dy_q, inv_dz_q;
  logic        [KINDS_W-1:0] kinds_q;
  logic signed [DATA_W-1:0]  coeff_q [COEFF_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dx_q <= INV_DX_RST;
      inv_dy_q <= INV_DY_RST;
      inv_dz_q <= INV_DZ_RST;
      kinds_q  <= KINDS_RST;
      for (int i = 0; i < COEFF_REGS; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INV_TWO_DX: inv_dx_q   <= cfg_wdata_i;
        REG_INV_TWO_DY: inv_dy_q   <= cfg_wdata_i;
        REG_INV_TWO_DZ: inv_dz_q   <= cfg_wdata_i;
        REG_TERM_KINDS: kinds_q    <= cfg_wdata_i[KINDS_W-1:0];
        REG_COEFF_0:    coeff_q[0] <= cfg_wdata_i;
        REG_COEFF_1:    coeff_q[1] <= cfg_wdata_i;
        REG_COEFF_2:    coeff_q[2] <= cfg_wdata_i;
        REG_COEFF_3:    coeff_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Stage k loads when it is empty or the stage after it moves on.
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] en;
  logic              in_acc, out_acc;

  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stages 1-3
  logic signed [DATA_W-1:0] u_in;
  logic signed [DATA_W-1:0] u1_q, u2_q, u3_q;
  logic signed [DATA_W-1:0] ux3, uy3, uz3;
  logic                     cx3, cy3, cz3;
  deriv_en_t                den;

  assign u_in     = s_axis_tdata[0 +: DATA_W];
  assign den.diff = en[0];
  assign den.prod = en[1];
  assign den.sat  = en[2];

  nsts_deriv u_deriv_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (den),
    .plus_i  (s_axis_tdata[2*DATA_W +: DATA_W]),
    .minus_i (s_axis_tdata[1*DATA_W +: DATA_W]),
    .inv_i   (inv_dx_q),
    .deriv_o (ux3),
    .clip_o  (cx3)
  );

  nsts_deriv u_deriv_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (den),
    .plus_i  (s_axis_tdata[4*DATA_W +: DATA_W]),
    .minus_i (s_axis_tdata[3*DATA_W +: DATA_W]),
    .inv_i   (inv_dy_q),
    .deriv_o (uy3),
    .clip_o  (cy3)
  );

  nsts_deriv u_deriv_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (den),
    .plus_i  (s_axis_tdata[6*DATA_W +: DATA_W]),
    .minus_i (s_axis_tdata[5*DATA_W +: DATA_W]),
    .inv_i   (inv_dz_q),
    .deriv_o (uz3),
    .clip_o  (cz3)
  );

  always_ff @(posedge clk_i) begin
    if (en[0]) u1_q <= u_in;
    if (en[1]) u2_q <= u1_q;
    if (en[2]) u3_q <= u2_q;
  end

  // ---------------------------------------------------------------- stage 4
  // Six shared products; each slot picks from these.
  logic signed [2*DATA_W-1:0] uux_q, uuy_q, uuz_q, xx_q, yy_q, zz_q;
  logic                       flag4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      uux_q <= mul32(u3_q, ux3);
      uuy_q <= mul32(u3_q, uy3);
      uuz_q <= mul32(u3_q, uz3);
      xx_q  <= mul32(ux3, ux3);
      yy_q  <= mul32(uy3, uy3);
      zz_q  <= mul32(uz3, uz3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag4_q <= 1'b0;
    end else if (en[3]) begin
      flag4_q <= cx3 | cy3 | cz3;
    end
  end

  // ---------------------------------------------------------------- stage 5
  sat_t s_uux, s_uuy, s_uuz, s_xx, s_yy, s_zz, s_grad;
  logic signed [DATA_W-1:0] p_d [TERM_SLOTS];
  logic        [TERM_SLOTS-1:0] pf_d;
  logic signed [DATA_W-1:0] p5_q [TERM_SLOTS];
  logic                     flag5_q;

  always_comb begin
    s_uux  = shift_sat(ext64(uux_q));
    s_uuy  = shift_sat(ext64(uuy_q));
    s_uuz  = shift_sat(ext64(uuz_q));
    s_xx   = shift_sat(ext64(xx_q));
    s_yy   = shift_sat(ext64(yy_q));
    s_zz   = shift_sat(ext64(zz_q));
    // squares are non-negative after clipping, so a 34-bit sum is exact
    s_grad = sat32(WIDE_W'(s_xx.val) + WIDE_W'(s_yy.val) + WIDE_W'(s_zz.val));
  end

  for (genvar s = 0; s < TERM_SLOTS; s++) begin : g_slot_sel
    kind_e kind;
    assign kind = kind_e'(kinds_q[s*KIND_W +: KIND_W]);

    always_comb begin
      unique case (kind)
        KIND_UUX:  begin p_d[s] = s_uux.val; pf_d[s] = s_uux.clip; end
        KIND_UUY:  begin p_d[s] = s_uuy.val; pf_d[s] = s_uuy.clip; end
        KIND_UUZ:  begin p_d[s] = s_uuz.val; pf_d[s] = s_uuz.clip; end
        KIND_UXUX: begin p_d[s] = s_xx.val;  pf_d[s] = s_xx.clip;  end
        KIND_UYUY: begin p_d[s] = s_yy.val;  pf_d[s] = s_yy.clip;  end
        KIND_UZUZ: begin p_d[s] = s_zz.val;  pf_d[s] = s_zz.clip;  end
        KIND_GRAD: begin
          p_d[s]  = s_grad.val;
          pf_d[s] = s_xx.clip | s_yy.clip | s_zz.clip | s_grad.clip;
        end
        KIND_NONE: begin p_d[s] = '0; pf_d[s] = 1'b0; end
        default:   begin p_d[s] = '0; pf_d[s] = 1'b0; end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en[4]) begin
        p5_q[s] <= p_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag5_q <= 1'b0;
    end else if (en[4]) begin
      flag5_q <= flag4_q | (|pf_d);
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic signed [2*DATA_W-1:0] term6_q [TERM_SLOTS];
  logic                       flag6_q;

  for (genvar s = 0; s < TERM_SLOTS; s++) begin : g_slot_mul
    always_ff @(posedge clk_i) begin
      if (en[5]) begin
        term6_q[s] <= mul32(coeff_q[s], p5_q[s]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag6_q <= 1'b0;
    end else if (en[5]) begin
      flag6_q <= flag5_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  sat_t                     t_sat [TERM_SLOTS];
  logic signed [WIDE_W-1:0] acc;
  logic                     tclip;
  sat_t                     sum_sat;
  logic signed [DATA_W-1:0] sum_q;
  logic                     sat_q;

  always_comb begin
    acc   = '0;
    tclip = 1'b0;
    for (int s = 0; s < TERM_SLOTS; s++) begin
      t_sat[s] = shift_sat(ext64(term6_q[s]));
      acc      = acc + WIDE_W'(t_sat[s].val);
      tclip    = tclip | t_sat[s].clip;
    end
    sum_sat = sat32(acc);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      sum_q <= sum_sat.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (en[6]) begin
      sat_q <= flag6_q | tclip | sum_sat.clip;
    end
  end

  assign m_axis_tvalid = vld_q[STAGES-1];
  assign m_axis_tdata  = sum_q;
  assign m_axis_tuser  = sat_q;

  // ---------------------------------------------------------------- checks
  // Input blocked only when the whole pipe is full behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q) && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  // Occupancy tracks accepted minus delivered words: nothing lost or repeated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) + $past(out_acc))
             == ($past($countones(vld_q)) + $past(in_acc)))
    else $error("pipeline occupancy does not match handshakes");

  // A stalled output stage keeps its flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tuser == $past(sat_q))
    else $error("saturation flag changed while output stalled");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the nonlinear stencil term sum block.
`timescale 1ns / 1ps

module testbench;
  import nsts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;

  localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh00010000;
  localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh00008000;
  localparam logic signed [79:0]       WIDE_MAX = 80'sh7FFFFFFF;
  localparam logic signed [79:0]       WIDE_MIN = -80'sh80000000;

  // one grid point; packed so u_center lands in the lowest tdata bits
  typedef struct packed {
    logic signed [DATA_W-1:0] u_z_plus;
    logic signed [DATA_W-1:0] u_z_minus;
    logic signed [DATA_W-1:0] u_y_plus;
    logic signed [DATA_W-1:0] u_y_minus;
    logic signed [DATA_W-1:0] u_x_plus;
    logic signed [DATA_W-1:0] u_x_minus;
    logic signed [DATA_W-1:0] u_center;
  } stencil_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] term_sum;
    logic                     saturated;
  } term_sum_t;

  // value after clipping to 32 bits, plus whether clipping happened
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } clamp_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [IN_FIELDS*DATA_W-1:0]   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [DATA_W-1:0]             m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i = '0;
  logic [DATA_W-1:0]             cfg_wdata_i = '0;

  // register shadow used by the predictor, at reset values
  logic [DATA_W-1:0]        scale_x = INV_DX_RST;
  logic [DATA_W-1:0]        scale_y = INV_DY_RST;
  logic [DATA_W-1:0]        scale_z = INV_DZ_RST;
  logic [KINDS_W-1:0]       slot_kinds = KINDS_RST;
  logic signed [DATA_W-1:0] slot_coef [COEFF_REGS] = '{default: '0};

  term_sum_t   sum_expect_q [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_reqs = 0;     // bumped by a test, served by the receiver
  int unsigned err_cnt = 0;
  int unsigned points_sent = 0;
  int unsigned results_seen = 0;
  int unsigned clipped_seen = 0;
  int unsigned cfg_loads = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned cycle_cnt = 0;

  nonlinear_stencil_term_sum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // u_center, u_x_minus, u_x_plus, u_y_minus,
                                     // u_y_plus, u_z_minus, u_z_plus
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // term_sum
    .m_axis_tuser  (m_axis_tuser),   // saturated
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: plain wide signed arithmetic, clip after every step
  // ---------------------------------------------------------------------------

  function automatic clamp_t clamp32(input logic signed [79:0] v);
    clamp_t r;
    r.clip = 1'b1;
    if (v > WIDE_MAX) r.val = Q_MAX;
    else if (v < WIDE_MIN) r.val = Q_MIN;
    else begin
      r.val  = v[DATA_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // fixed-point product, floor rounded by the arithmetic shift
  function automatic clamp_t qmul(input logic signed [DATA_W-1:0] a,
                                  input logic signed [DATA_W-1:0] b);
    logic signed [79:0] wa;
    logic signed [79:0] wb;
    wa = a;
    wb = b;
    return clamp32((wa * wb) >>> FRAC_BITS);
  endfunction

  // central difference times an unsigned inverse spacing
  function automatic clamp_t slope(input logic signed [DATA_W-1:0] hi,
                                   input logic signed [DATA_W-1:0] lo,
                                   input logic [DATA_W-1:0] scale);
    logic signed [79:0] d;
    logic signed [79:0] k;
    d = hi;
    d = d - lo;
    k = {48'd0, scale};
    return clamp32((d * k) >>> FRAC_BITS);
  endfunction

  function automatic term_sum_t predict_term_sum(input stencil_t p);
    clamp_t             gx, gy, gz, prod, term, sqx, sqy, sqz;
    logic signed [79:0] acc;
    logic signed [79:0] grad;
    logic               flag;
    kind_e              kind;
    term_sum_t          r;
    gx   = slope(p.u_x_plus, p.u_x_minus, scale_x);
    gy   = slope(p.u_y_plus, p.u_y_minus, scale_y);
    gz   = slope(p.u_z_plus, p.u_z_minus, scale_z);
    // a clipped derivative flags the point even if no slot uses it
    flag = gx.clip | gy.clip | gz.clip;
    acc  = '0;
    for (int s = 0; s < TERM_SLOTS; s++) begin
      kind = kind_e'(slot_kinds[KIND_W*s +: KIND_W]);
      prod = '0;
      case (kind)
        KIND_UUX:  prod = qmul(p.u_center, gx.val);
        KIND_UUY:  prod = qmul(p.u_center, gy.val);
        KIND_UUZ:  prod = qmul(p.u_center, gz.val);
        KIND_UXUX: prod = qmul(gx.val, gx.val);
        KIND_UYUY: prod = qmul(gy.val, gy.val);
        KIND_UZUZ: prod = qmul(gz.val, gz.val);
        KIND_GRAD: begin
          sqx  = qmul(gx.val, gx.val);
          sqy  = qmul(gy.val, gy.val);
          sqz  = qmul(gz.val, gz.val);
          grad = sqx.val;
          grad = grad + sqy.val + sqz.val;
          prod = clamp32(grad);
          prod.clip = prod.clip | sqx.clip | sqy.clip | sqz.clip;
        end
        default: prod = '0;
      endcase
      if (kind != KIND_NONE) begin
        term = qmul(slot_coef[s], prod.val);
        flag = flag | prod.clip | term.clip;
        acc  = acc + term.val;
      end
    end
    term        = clamp32(acc);
    r.term_sum  = term.val;
    r.saturated = flag | term.clip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stencil_t point(input logic signed [DATA_W-1:0] c,
                                     input logic signed [DATA_W-1:0] xm,
                                     input logic signed [DATA_W-1:0] xp,
                                     input logic signed [DATA_W-1:0] ym,
                                     input logic signed [DATA_W-1:0] yp,
                                     input logic signed [DATA_W-1:0] zm,
                                     input logic signed [DATA_W-1:0] zp);
    stencil_t p;
    p.u_center  = c;
    p.u_x_minus = xm;
    p.u_x_plus  = xp;
    p.u_y_minus = ym;
    p.u_y_plus  = yp;
    p.u_z_minus = zm;
    p.u_z_plus  = zp;
    return p;
  endfunction

  function automatic logic [KINDS_W-1:0] pack_kinds(input kind_e k0, input kind_e k1,
                                                    input kind_e k2, input kind_e k3);
    return {k3, k2, k1, k0};
  endfunction

  // uniform in [-mag, mag]
  function automatic logic signed [DATA_W-1:0] spread(input int unsigned mag);
    int r;
    r = int'($urandom_range(2 * mag, 0)) - int'(mag);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] corner_value();
    case ($urandom_range(4, 0))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // mostly a smooth field, some full-range noise, some extreme values
  function automatic stencil_t random_point();
    stencil_t    p;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 70) begin
      p.u_center  = spread(1 << 20);
      p.u_x_minus = p.u_center + spread(1 << 17);
      p.u_x_plus  = p.u_center + spread(1 << 17);
      p.u_y_minus = p.u_center + spread(1 << 17);
      p.u_y_plus  = p.u_center + spread(1 << 17);
      p.u_z_minus = p.u_center + spread(1 << 17);
      p.u_z_plus  = p.u_center + spread(1 << 17);
    end else if (pick < 90) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      p = point(corner_value(), corner_value(), corner_value(), corner_value(),
                corner_value(), corner_value(), corner_value());
    end
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] random_scale();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 80) return $urandom_range(1 << 19, 1 << 10);
    if (pick < 88) return '0;
    if (pick < 94) return '1;
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_coef();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 75) return spread(1 << 18);
    if (pick < 85) return $urandom;
    return corner_value();
  endfunction

  // one register write per clock; shadow follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_INV_TWO_DX: scale_x = data;
      REG_INV_TWO_DY: scale_y = data;
      REG_INV_TWO_DZ: scale_z = data;
      REG_TERM_KINDS: slot_kinds = data[KINDS_W-1:0];
      REG_COEFF_0:    slot_coef[0] = data;
      REG_COEFF_1:    slot_coef[1] = data;
      REG_COEFF_2:    slot_coef[2] = data;
      REG_COEFF_3:    slot_coef[3] = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [DATA_W-1:0] dx, input logic [DATA_W-1:0] dy,
                             input logic [DATA_W-1:0] dz, input logic [KINDS_W-1:0] kinds,
                             input logic signed [DATA_W-1:0] c0,
                             input logic signed [DATA_W-1:0] c1,
                             input logic signed [DATA_W-1:0] c2,
                             input logic signed [DATA_W-1:0] c3);
    write_reg(REG_INV_TWO_DX, dx);
    write_reg(REG_INV_TWO_DY, dy);
    write_reg(REG_INV_TWO_DZ, dz);
    write_reg(REG_TERM_KINDS, {{(DATA_W-KINDS_W){1'b0}}, kinds});
    write_reg(REG_COEFF_0, c0);
    write_reg(REG_COEFF_1, c1);
    write_reg(REG_COEFF_2, c2);
    write_reg(REG_COEFF_3, c3);
    cfg_we_i <= 1'b0;
    cfg_loads++;
  endtask

  // offer one point, wait for the handshake, then record the expected result;
  // each cycle before the offer idles with the set percentage
  task automatic push_point(input stencil_t p);
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sum_expect_q.push_back(predict_term_sum(p));
    points_sent++;
  endtask

  // stop offering and wait for every pending result (block is then idle)
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sum_expect_q.size() != 0);
  endtask

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random tready plus the long hold-off, counted here
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  // results are sampled mid-cycle: the handshake completes at the next edge
  always @(negedge clk_i) begin : check_results
    term_sum_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser) clipped_seen++;
        if (sum_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected result term_sum=%h saturated=%b",
                               m_axis_tdata, m_axis_tuser));
        end else begin
          want = sum_expect_q.pop_front();
          if (m_axis_tdata !== want.term_sum)
            flag_error($sformatf("term_sum expected %h got %h", want.term_sum, m_axis_tdata));
          if (m_axis_tuser !== want.saturated)
            flag_error($sformatf("saturated expected %b got %b (term_sum %h)",
                                 want.saturated, m_axis_tuser, want.term_sum));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset registers: every kind is none, but a clipped derivative still flags
  task automatic test_reset_state();
    push_point(point(0, 0, 0, 0, 0, 0, 0));
    push_point(point(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    push_point(point(Q_ONE, -Q_ONE, Q_ONE, 3, -5, 7, 7));
    drain();
  endtask

  // advection kinds and ux squared in 3D; odd negatives check floor rounding
  task automatic test_first_kinds();
    load_config(32'd65536, 32'd32768, 32'd131072,
                pack_kinds(KIND_UUX, KIND_UUY, KIND_UUZ, KIND_UXUX),
                Q_ONE, -Q_ONE, Q_HALF, 2 * Q_ONE);
    push_point(point(2 * Q_ONE, Q_ONE, 3 * Q_ONE, -Q_ONE, Q_ONE, 0, Q_HALF));
    push_point(point(-3, 5, -6, 7, 2, -1, 4));
    push_point(point(Q_MAX, -(1 << 24), 1 << 24, 0, 0, 0, 0));
    push_point(point(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
    push_point(point(-1, -1, -1, -1, -1, -1, -1));
    drain();
  endtask

  // squares, gradient and none in 2D mode, extreme x scale, tiny y scale
  task automatic test_second_kinds();
    load_config('1, 32'd1, 32'd0,
                pack_kinds(KIND_UYUY, KIND_UZUZ, KIND_GRAD, KIND_NONE),
                Q_MAX, Q_MIN, Q_ONE, Q_MAX);
    push_point(point(Q_ONE, 0, 1, 0, Q_ONE, Q_ONE, 0));
    push_point(point(0, 0, 0, -Q_ONE, Q_ONE, 0, 0));
    push_point(point(5, 10, -10, 100, -100, Q_MIN, Q_MAX));   // z ignored in 2D
    push_point(point(0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0));
    push_point(point(0, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  // four full-scale terms that fit alone but overflow when added
  task automatic test_sum_clip();
    load_config(32'd65536, 32'd0, 32'd0, '0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    push_point(point(Q_ONE, 0, 1 << 15, 0, 0, 0, 0));
    push_point(point(Q_ONE, 1 << 15, 0, 0, 0, 0, 0));
    push_point(point(Q_MIN, Q_MIN, Q_MAX, 0, 0, 0, 0));
    push_point(point(Q_ONE, 0, 1, 0, 0, 0, 0));
    drain();
  endtask

  // all three scales at maximum
  task automatic test_wide_scales();
    load_config('1, '1, '1, pack_kinds(KIND_GRAD, KIND_GRAD, KIND_UXUX, KIND_UUZ),
                Q_MIN, Q_HALF, -Q_HALF, 32'sd1);
    push_point(point(0, 7, 7, 7, 7, 7, 7));
    push_point(point(1, 0, 1, 0, -1, 0, 1));
    push_point(point(-Q_ONE, 0, 1 << 16, 0, 0, 1 << 15, 0));
    push_point(point(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    drain();
  endtask

  // receiver holds off while points keep coming: pipeline fills, input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_config(random_scale(), random_scale(), random_scale(),
                KINDS_W'($urandom_range(4095, 0)),
                random_coef(), random_coef(), random_coef(), random_coef());
    hold_reqs++;
    repeat (30) push_point(random_point());
    drain();
  endtask

  // random points in chunks, fresh random registers per chunk
  task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int chunk = 0; chunk < 6; chunk++) begin
      load_config(random_scale(), random_scale(),
                  ($urandom_range(99, 0) < 30) ? '0 : random_scale(),
                  KINDS_W'($urandom_range(4095, 0)),
                  random_coef(), random_coef(), random_coef(), random_coef());
      repeat (count / 6) push_point(random_point());
      drain();
    end
  endtask

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 35;
    rx_idle_pct = 59;
    test_reset_state();
    test_first_kinds();
    test_second_kinds();
    test_sum_clip();
    test_wide_scales();
    test_backpressure();
    test_random(35, 59, 468);
    test_random(59, 35, 468);
    test_random(0, 0, 468);

    // nothing pending; give stray words time to show up
    repeat (4 * STAGES) @(posedge clk_i);
    if (sum_expect_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", sum_expect_q.size()));

    $display("Sent %0d stencil points over %0d register loads (all term kinds, 2D and 3D).",
             points_sent, cfg_loads);
    $display("Checked %0d results, %0d saturated; input stalled %0d cycles; %0d errors.",
             results_seen, clipped_seen, in_stall_cycles, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
